[sv/a2i_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package a2i_pkg;

  localparam int VALUE_W = 32;
  localparam int BASE_W = 5;
  localparam int DIGIT_W = 5;
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-1:0] REG_BASE_SETTING = 2'd0;

  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_BIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_F = 8'h46;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_F = 8'h66;
  localparam logic [7:0] CH_LO_X = 8'h78;
  localparam logic [7:0] CH_LO_O = 8'h6F;
  localparam logic [7:0] CH_LO_B = 8'h62;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_BAD_BASE = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               ws;
    logic               plus;
    logic               minus;
    logic               zero;
    logic               pfx_x;
    logic               pfx_o;
    logic               pfx_b;
    logic               nul;
    logic               last;
  } cls_t;

  typedef enum logic [4:0] {
    PH_LEAD    = 5'b00001,
    PH_PREFIX  = 5'b00010,
    PH_ZERO    = 5'b00100,
    PH_DIGITS  = 5'b01000,
    PH_BADBASE = 5'b10000
  } phase_t;

  function automatic logic base_ok(input logic [BASE_W-1:0] b);
    base_ok = (b == BASE_AUTO) || (b == BASE_BIN) || (b == BASE_OCT) ||
              (b == BASE_DEC) || (b == BASE_HEX);
  endfunction

endpackage

`default_nettype wire

[sv/a2i_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module a2i_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire a2i_pkg::in_item_t in_data,
  output logic                   push,
  output a2i_pkg::cls_t          push_data,
  input  wire logic              q_ready
);

  logic [7:0] c;

  assign c = in_data.char_in;
  assign in_ready = q_ready;
  assign push = in_valid && q_ready;

  always_comb begin
    push_data = '0;
    if (c >= a2i_pkg::CH_ZERO && c <= a2i_pkg::CH_NINE) begin
      push_data.digit = a2i_pkg::DIGIT_W'(c - a2i_pkg::CH_ZERO);
    end else if (c >= a2i_pkg::CH_UP_A && c <= a2i_pkg::CH_UP_F) begin
      push_data.digit = a2i_pkg::DIGIT_W'(c - a2i_pkg::CH_UP_A + 8'd10);
    end else if (c >= a2i_pkg::CH_LO_A && c <= a2i_pkg::CH_LO_F) begin
      push_data.digit = a2i_pkg::DIGIT_W'(c - a2i_pkg::CH_LO_A + 8'd10);
    end else begin
      push_data.digit = a2i_pkg::DIGIT_NONE;
    end
    push_data.ws = (c != 8'd0) && (c <= a2i_pkg::CH_SPACE);
    push_data.plus = (c == a2i_pkg::CH_PLUS);
    push_data.minus = (c == a2i_pkg::CH_MINUS);
    push_data.zero = (c == a2i_pkg::CH_ZERO);
    push_data.pfx_x = (c == a2i_pkg::CH_LO_X);
    push_data.pfx_o = (c == a2i_pkg::CH_LO_O);
    push_data.pfx_b = (c == a2i_pkg::CH_LO_B);
    push_data.nul = (c == 8'd0);
    push_data.last = in_data.last;
  end

endmodule

`default_nettype wire

[sv/a2i_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module a2i_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire a2i_pkg::cls_t push_data,
  output logic               push_ready,
  input  wire logic          pop,
  output a2i_pkg::cls_t      pop_data,
  output logic               pop_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  a2i_pkg::cls_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push = push && push_ready;
  assign do_pop = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/a2i_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module a2i_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [a2i_pkg::BASE_W-1:0]    base_setting,
  input  wire logic                          q_valid,
  input  wire a2i_pkg::cls_t                 q_data,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output a2i_pkg::out_item_t                 out_data
);

  localparam int VW = a2i_pkg::VALUE_W;

  a2i_pkg::phase_t               phase_r, phase_nxt;
  logic                          neg_r, neg_nxt;
  logic [a2i_pkg::BASE_W-1:0]    base_r, base_nxt;
  logic [VW-1:0]                 acc_r, acc_nxt;
  logic                          ended_r, ended_nxt;
  logic                          out_valid_r;
  a2i_pkg::out_item_t            out_data_r, out_data_nxt;
  logic                          do_digit;
  logic                          ends;
  logic                          auto_b;
  logic                          bad;
  logic [VW-1:0]                 scaled;

  assign ends = q_data.nul || q_data.last;
  assign pop = q_valid && (!ends || !out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign auto_b = (base_setting == a2i_pkg::BASE_AUTO);

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt = neg_r;
    base_nxt = base_r;
    do_digit = 1'b0;
    if (!q_data.nul) begin
      unique case (phase_r)
        a2i_pkg::PH_BADBASE: begin
        end
        a2i_pkg::PH_LEAD: begin
          if (q_data.ws) begin
          end else if (!a2i_pkg::base_ok(base_setting)) begin
            phase_nxt = a2i_pkg::PH_BADBASE;
          end else begin
            base_nxt = auto_b ? a2i_pkg::BASE_DEC : base_setting;
            if (q_data.plus || q_data.minus) begin
              neg_nxt = q_data.minus;
              phase_nxt = auto_b ? a2i_pkg::PH_PREFIX : a2i_pkg::PH_DIGITS;
            end else if (auto_b && q_data.zero) begin
              phase_nxt = a2i_pkg::PH_ZERO;
            end else begin
              phase_nxt = a2i_pkg::PH_DIGITS;
              do_digit = 1'b1;
            end
          end
        end
        a2i_pkg::PH_PREFIX: begin
          if (q_data.zero) begin
            phase_nxt = a2i_pkg::PH_ZERO;
          end else begin
            phase_nxt = a2i_pkg::PH_DIGITS;
            do_digit = 1'b1;
          end
        end
        a2i_pkg::PH_ZERO: begin
          phase_nxt = a2i_pkg::PH_DIGITS;
          if (q_data.pfx_x) begin
            base_nxt = a2i_pkg::BASE_HEX;
          end else if (q_data.pfx_o) begin
            base_nxt = a2i_pkg::BASE_OCT;
          end else if (q_data.pfx_b) begin
            base_nxt = a2i_pkg::BASE_BIN;
          end else begin
            do_digit = 1'b1;
          end
        end
        a2i_pkg::PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
          phase_nxt = a2i_pkg::PH_LEAD;
        end
      endcase
    end
  end

  // The base is always one of a few fixed values here, so the multiply is shift and add.
  always_comb begin
    case (base_nxt)
      a2i_pkg::BASE_BIN: scaled = {acc_r[VW-2:0], 1'b0};
      a2i_pkg::BASE_OCT: scaled = {acc_r[VW-4:0], 3'b000};
      a2i_pkg::BASE_DEC: scaled = {acc_r[VW-4:0], 3'b000} + {acc_r[VW-2:0], 1'b0};
      a2i_pkg::BASE_HEX: scaled = {acc_r[VW-5:0], 4'b0000};
      default:           scaled = acc_r;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    ended_nxt = ended_r;
    if (do_digit && !ended_r) begin
      if (q_data.digit >= base_nxt) begin
        ended_nxt = 1'b1;
      end else begin
        acc_nxt = scaled + VW'(q_data.digit);
      end
    end
  end

  always_comb begin
    bad = (phase_nxt == a2i_pkg::PH_BADBASE) ||
          ((phase_nxt == a2i_pkg::PH_LEAD) && !a2i_pkg::base_ok(base_setting));
    out_data_nxt.status = bad ? a2i_pkg::STATUS_BAD_BASE : a2i_pkg::STATUS_OK;
    if (bad) begin
      out_data_nxt.value = '0;
    end else if (neg_nxt) begin
      out_data_nxt.value = '0 - acc_nxt;
    end else begin
      out_data_nxt.value = acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= a2i_pkg::PH_LEAD;
      neg_r <= 1'b0;
      base_r <= a2i_pkg::BASE_DEC;
      acc_r <= '0;
      ended_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (ends) begin
          phase_r <= a2i_pkg::PH_LEAD;
          neg_r <= 1'b0;
          base_r <= a2i_pkg::BASE_DEC;
          acc_r <= '0;
          ended_r <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          neg_r <= neg_nxt;
          base_r <= base_nxt;
          acc_r <= acc_nxt;
          ended_r <= ended_nxt;
        end
      end
      if (pop && ends) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ends) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && ends) |=> (phase_r == a2i_pkg::PH_LEAD) && (acc_r == '0) && !neg_r && !ended_r)
    else $error("string state not cleared after a result");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == a2i_pkg::STATUS_BAD_BASE)) |-> (out_data_r.value == '0))
    else $error("invalid base result carries a nonzero value");

  a_ended_in_digits: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> (phase_r == a2i_pkg::PH_DIGITS))
    else $error("accumulation stopped outside the digit phase");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(pop && ends))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

[sv/ascii_to_integer_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// Parses a string of ASCII characters, one per input transaction, into a 32-bit value in the
// manner of strtoul: leading bytes 1 to 32 are skipped, one sign may follow, auto base (register
// value 0) detects 0x, 0o or 0b prefixes, and digits accumulate with wrap until the first
// character that is not a digit of the base. A result transaction follows the character flagged
// last or a zero byte; a minus sign negates the value, and a base other than 0, 2, 8, 10 or 16
// gives status 1 with value 0. One character is taken per cycle while the classifier queue has
// room; the result is registered after the classifier queue, and the back end accumulates one
// character per cycle with a shift-and-add step unless an ending character waits for
// a pending result. Write the base register at byte address 0 only while no string is in flight.
module ascii_to_integer_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire a2i_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output a2i_pkg::out_item_t                out_data,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [a2i_pkg::APB_AW-1:0]   cfg_paddr,
  input  wire logic [a2i_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [a2i_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  logic [a2i_pkg::BASE_W-1:0] base_setting_r;
  logic                       push, q_ready, q_valid, pop;
  a2i_pkg::cls_t              push_data, q_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == a2i_pkg::REG_BASE_SETTING) ?
                      a2i_pkg::APB_DW'(base_setting_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_setting_r <= a2i_pkg::BASE_AUTO;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr == a2i_pkg::REG_BASE_SETTING)) begin
      base_setting_r <= cfg_pwdata[a2i_pkg::BASE_W-1:0];
    end
  end

  a2i_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready)
  );

  a2i_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_data   (q_data),
    .pop_valid  (q_valid)
  );

  a2i_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .base_setting (base_setting_r),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire
